// ===== hw/rtl/vtc_pkg.sv =====
// View transform composer package: opcodes, transform codes and the
// command/status structs that pass between the controller and the datapath.
// No dependencies.
`default_nettype none

package vtc_pkg;

    localparam int MATRIX_DIM = 4;
    localparam int MSIZE      = MATRIX_DIM * MATRIX_DIM;

    // Q30 trig constants, rounded to the working fraction in the datapath
    localparam longint COS10_Q30 = 1057429273;
    localparam longint SIN10_Q30 = 186453311;
    localparam longint COS45_Q30 = 759250125;

    // Reset values of the screen size registers
    localparam logic [13:0] WIDTH_RESET  = 14'd640;
    localparam logic [13:0] HEIGHT_RESET = 14'd480;

    // Register indexes on the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Request opcodes
    localparam logic [3:0] OP_MAP_FWD    = 4'd0;
    localparam logic [3:0] OP_MAP_INV    = 4'd1;
    localparam logic [3:0] OP_UP         = 4'd2;
    localparam logic [3:0] OP_RIGHT      = 4'd3;
    localparam logic [3:0] OP_DOWN       = 4'd4;
    localparam logic [3:0] OP_LEFT       = 4'd5;
    localparam logic [3:0] OP_OUT        = 4'd6;
    localparam logic [3:0] OP_IN         = 4'd7;
    localparam logic [3:0] OP_SCALE_UP   = 4'd8;
    localparam logic [3:0] OP_SCALE_DN   = 4'd9;
    localparam logic [3:0] OP_RX_NEG     = 4'd10;
    localparam logic [3:0] OP_RX_POS     = 4'd11;
    localparam logic [3:0] OP_RY_NEG     = 4'd12;
    localparam logic [3:0] OP_RY_POS     = 4'd13;
    localparam logic [3:0] OP_RESET_VIEW = 4'd14;
    localparam logic [3:0] OP_NOP        = 4'd15;

    // Fixed transforms that the datapath generates element by element
    typedef enum logic [4:0] {
        TC_TX_POS, TC_TX_NEG, TC_TY_POS, TC_TY_NEG, TC_TZ_POS, TC_TZ_NEG,
        TC_ORIGIN, TC_CENTRE, TC_SCALE_UP, TC_SCALE_DN,
        TC_RX_NEG, TC_RX_POS, TC_RY_NEG, TC_RY_POS,
        TC_RX90_POS, TC_RX90_NEG, TC_RY45_NEG, TC_RY45_POS
    } tcode_t;

    // Product kind: T*F, I*Ti, or matrix times point
    typedef enum logic [1:0] {PT_FWD, PT_INV, PT_MAP} ptype_t;

    typedef struct packed {
        logic        issue;
        ptype_t      ptype;
        tcode_t      tcode;
        logic        msel;       // map: 0 forward, 1 inverse
        logic [1:0]  ri;
        logic [1:0]  rj;
        logic [1:0]  rk;
        logic        copy;
        logic        copy_inv;
        logic [3:0]  copy_idx;
        logic        load_init;
        logic        load_point;
        logic        publish;
    } vtc_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } vtc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/view_transform_composer_core.sv =====
// View transform composer top level: stream ports, size registers,
// controller and datapath. Depends on vtc_pkg, vtc_ctrl, vtc_datapath.
//
// Usage: requests enter on the s_axis channel. Opcodes 0 and 1 map a
// Q16.16 point through the forward or inverse matrix and return one result
// on m_axis; opcodes 2 to 14 update both matrices and return nothing;
// opcode 15 is dropped. All arithmetic runs on one shared 32x32
// multiply-accumulate unit, one product per cycle while a pass issues.
// Sequence: a map issues its 16 products, drains the pipeline and then
// publishes its result. A matrix product issues 64 products, drains the
// pipeline and copies its 16 elements back; a translation runs two products,
// a scale or rotation about the centre six, a view reset a load of the
// initial view plus twelve products. One request is in work at a time;
// s_axis_tready is high only while the block is idle.
// Reset: the block rebuilds the initial view for 640x480
// with s_axis_tready low. A map result waits in the output register while
// m_axis_tready is low; the next request is still taken and held back only
// when its own result is ready to publish.
`default_nettype none

module view_transform_composer_core
    import vtc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,   // opcode, point_x, point_y, point_z, point_w, pad
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // out_x, out_y, out_z, out_w
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [13:0]  cfg_data
);

    logic [13:0] width_reg, height_reg;
    vtc_cmd_t    cmd;
    vtc_stat_t   stat;
    logic signed [31:0] ox, oy, oz, ow;

    // Screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            if (cfg_index == REG_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    vtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tdata[3:0]),
        .stat      (stat),
        .cmd       (cmd)
    );

    vtc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .point_x       (s_axis_tdata[35:4]),
        .point_y       (s_axis_tdata[67:36]),
        .point_z       (s_axis_tdata[99:68]),
        .point_w       (s_axis_tdata[131:100]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_x         (ox),
        .out_y         (oy),
        .out_z         (oz),
        .out_w         (ow)
    );

    assign m_axis_tdata = {ow, oz, oy, ox};

endmodule

`default_nettype wire

// ===== hw/rtl/vtc_ctrl.sv =====
// View transform composer controller: sequences map, matrix product and
// copy passes for each request. Depends on vtc_pkg.
`default_nettype none

module vtc_ctrl
    import vtc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic [3:0] in_opcode,
    input  wire vtc_stat_t stat,
    output vtc_cmd_t       cmd
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ISSUE, S_WAIT, S_COPY, S_PUB} state_t;

    state_t      state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic [2:0]  phase_reg, phase_next;
    logic        side_reg, side_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic        is_map;
    logic        issue_end;
    logic [2:0]  last_phase;
    logic [1:0]  sub;
    tcode_t      fcode, icode, mid_f, mid_i;

    assign is_map   = (op_reg == OP_MAP_FWD) || (op_reg == OP_MAP_INV);
    assign in_ready = (state_reg == S_IDLE);
    assign issue_end = is_map ? (cnt_reg[3:0] == 4'd15) : (cnt_reg == 6'd63);

    // Index of the last transform phase for the request
    always_comb
    begin
        if (op_reg == OP_RESET_VIEW)
            last_phase = 3'd5;
        else if (op_reg >= OP_SCALE_UP)
            last_phase = 3'd2;
        else
            last_phase = 3'd0;
    end

    // Transform pair for the current phase
    always_comb
    begin
        mid_f = TC_TX_POS;
        mid_i = TC_TX_NEG;
        sub   = (phase_reg >= 3'd3) ? 2'(phase_reg - 3'd3) : phase_reg[1:0];
        unique case (op_reg)
            OP_UP:       begin mid_f = TC_TY_NEG;   mid_i = TC_TY_POS;   end
            OP_RIGHT:    begin mid_f = TC_TX_POS;   mid_i = TC_TX_NEG;   end
            OP_DOWN:     begin mid_f = TC_TY_POS;   mid_i = TC_TY_NEG;   end
            OP_LEFT:     begin mid_f = TC_TX_NEG;   mid_i = TC_TX_POS;   end
            OP_OUT:      begin mid_f = TC_TZ_NEG;   mid_i = TC_TZ_POS;   end
            OP_IN:       begin mid_f = TC_TZ_POS;   mid_i = TC_TZ_NEG;   end
            OP_SCALE_UP: begin mid_f = TC_SCALE_UP; mid_i = TC_SCALE_DN; end
            OP_SCALE_DN: begin mid_f = TC_SCALE_DN; mid_i = TC_SCALE_UP; end
            OP_RX_NEG:   begin mid_f = TC_RX_NEG;   mid_i = TC_RX_POS;   end
            OP_RX_POS:   begin mid_f = TC_RX_POS;   mid_i = TC_RX_NEG;   end
            OP_RY_NEG:   begin mid_f = TC_RY_NEG;   mid_i = TC_RY_POS;   end
            OP_RY_POS:   begin mid_f = TC_RY_POS;   mid_i = TC_RY_NEG;   end
            OP_RESET_VIEW:
            begin
                if (phase_reg >= 3'd3)
                begin
                    mid_f = TC_RY45_NEG;
                    mid_i = TC_RY45_POS;
                end
                else
                begin
                    mid_f = TC_RX90_POS;
                    mid_i = TC_RX90_NEG;
                end
            end
            default:     begin mid_f = TC_TX_POS;   mid_i = TC_TX_NEG;   end
        endcase
        // centred: move to origin, transform, move back
        if (last_phase != 3'd0 && sub == 2'd0)
        begin
            fcode = TC_ORIGIN;
            icode = TC_CENTRE;
        end
        else if (last_phase != 3'd0 && sub == 2'd2)
        begin
            fcode = TC_CENTRE;
            icode = TC_ORIGIN;
        end
        else
        begin
            fcode = mid_f;
            icode = mid_i;
        end
    end

    // Command decode
    always_comb
    begin
        cmd            = '0;
        cmd.ptype      = is_map ? PT_MAP : (side_reg ? PT_INV : PT_FWD);
        cmd.tcode      = side_reg ? icode : fcode;
        cmd.msel       = op_reg[0];
        cmd.rk         = cnt_reg[1:0];
        cmd.rj         = is_map ? 2'd0 : cnt_reg[3:2];
        cmd.ri         = is_map ? cnt_reg[3:2] : cnt_reg[5:4];
        cmd.issue      = (state_reg == S_ISSUE);
        cmd.copy       = (state_reg == S_COPY);
        cmd.copy_inv   = side_reg;
        cmd.copy_idx   = cnt_reg[3:0];
        cmd.load_init  = (state_reg == S_LOAD);
        cmd.load_point = in_valid && in_ready;
        cmd.publish    = (state_reg == S_PUB) && stat.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        side_next  = side_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_opcode != OP_NOP)
                begin
                    op_next    = in_opcode;
                    phase_next = 3'd0;
                    side_next  = 1'b0;
                    cnt_next   = 6'd0;
                    state_next = (in_opcode == OP_RESET_VIEW) ? S_LOAD : S_ISSUE;
                end
            end
            S_LOAD:
                state_next = S_ISSUE;
            S_ISSUE:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (issue_end)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!stat.busy)
                begin
                    cnt_next   = 6'd0;
                    state_next = is_map ? S_PUB : S_COPY;
                end
            end
            S_COPY:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'd15)
                begin
                    cnt_next = 6'd0;
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = S_ISSUE;
                    end
                    else if (phase_reg == last_phase)
                        state_next = S_IDLE;
                    else
                    begin
                        side_next  = 1'b0;
                        phase_next = phase_reg + 3'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_PUB:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State; reset rebuilds the initial view
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            op_reg    <= OP_RESET_VIEW;
            phase_reg <= 3'd0;
            side_reg  <= 1'b0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            phase_reg <= phase_next;
            side_reg  <= side_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vtc_datapath.sv =====
// View transform composer datapath: matrix storage, transform element
// generator, multiply-accumulate pipeline and output register. Uses vtc_pkg.
`default_nettype none

module vtc_datapath
    import vtc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vtc_cmd_t           cmd,
    output vtc_stat_t               stat,
    input  wire logic [13:0]        screen_width,
    input  wire logic [13:0]        screen_height,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic signed [31:0] point_w,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic signed [31:0]      out_w
);

    localparam logic signed [31:0] ONE   = 32'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [31:0] TWO   = 32'(64'sd2 <<< FRAC_BITS);
    localparam logic signed [31:0] HALF  = 32'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [31:0] STEP  = 32'(64'sd10 <<< FRAC_BITS);
    localparam logic signed [63:0] C10_L =
        (64'(COS10_Q30) + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam logic signed [63:0] S10_L =
        (64'(SIN10_Q30) + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam logic signed [63:0] C45_L =
        (64'(COS45_Q30) + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam logic signed [31:0] C10 = C10_L[31:0];
    localparam logic signed [31:0] S10 = S10_L[31:0];
    localparam logic signed [31:0] C45 = C45_L[31:0];
    localparam logic signed [65:0] RND = 66'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [65:0] SAT_HI = 66'sh7FFFFFFF;
    localparam logic signed [65:0] SAT_LO = -66'sh80000000;

    logic signed [31:0] fwd_reg [MSIZE];
    logic signed [31:0] inv_reg [MSIZE];
    logic signed [31:0] tmp_reg [MSIZE];
    logic signed [31:0] pt_reg  [MATRIX_DIM];
    logic signed [31:0] res_reg [MATRIX_DIM];

    logic signed [63:0] prod_reg, prod_next;
    logic signed [65:0] acc_reg, acc_next;
    logic               v1_reg, v2_reg;
    logic               first1_reg, last1_reg, map1_reg, last2_reg, map2_reg;
    logic [3:0]         dst1_reg, dst2_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg, out_w_reg;

    logic [39:0]        hw_wide, hh_wide;
    logic signed [31:0] hw, hh;
    logic [3:0]         f_idx;
    logic signed [31:0] f_rd, i_rd, t_val, op_a, op_b;
    logic [1:0]         t_r, t_c;
    logic signed [65:0] rnd_sum, shifted;
    logic signed [31:0] sat_val;

    // Half screen size in fixed point, saturated
    always_comb
    begin
        hw_wide = 40'(screen_width[13:1]) << FRAC_BITS;
        hh_wide = 40'(screen_height[13:1]) << FRAC_BITS;
        hw = (hw_wide > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : hw_wide[31:0];
        hh = (hh_wide > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : hh_wide[31:0];
    end

    // One element of a fixed transform matrix
    function automatic logic signed [31:0] tf_elem(
        input tcode_t             code,
        input logic [1:0]         r,
        input logic [1:0]         c,
        input logic signed [31:0] hx,
        input logic signed [31:0] hy
    );
        logic               is_tr, is_dg, is_rx, is_ry;
        logic signed [31:0] tx, ty, tz, dv, cv, sv, res;
        is_tr = 1'b0; is_dg = 1'b0; is_rx = 1'b0; is_ry = 1'b0;
        tx = '0; ty = '0; tz = '0; dv = ONE; cv = ONE; sv = '0;
        unique case (code)
            TC_TX_POS:   begin is_tr = 1'b1; tx = STEP;  end
            TC_TX_NEG:   begin is_tr = 1'b1; tx = -STEP; end
            TC_TY_POS:   begin is_tr = 1'b1; ty = STEP;  end
            TC_TY_NEG:   begin is_tr = 1'b1; ty = -STEP; end
            TC_TZ_POS:   begin is_tr = 1'b1; tz = STEP;  end
            TC_TZ_NEG:   begin is_tr = 1'b1; tz = -STEP; end
            TC_ORIGIN:   begin is_tr = 1'b1; tx = -hx; ty = -hy; end
            TC_CENTRE:   begin is_tr = 1'b1; tx = hx;  ty = hy;  end
            TC_SCALE_UP: begin is_dg = 1'b1; dv = TWO;  end
            TC_SCALE_DN: begin is_dg = 1'b1; dv = HALF; end
            TC_RX_NEG:   begin is_rx = 1'b1; cv = C10; sv = -S10; end
            TC_RX_POS:   begin is_rx = 1'b1; cv = C10; sv = S10;  end
            TC_RY_NEG:   begin is_ry = 1'b1; cv = C10; sv = -S10; end
            TC_RY_POS:   begin is_ry = 1'b1; cv = C10; sv = S10;  end
            TC_RX90_POS: begin is_rx = 1'b1; cv = '0;  sv = ONE;  end
            TC_RX90_NEG: begin is_rx = 1'b1; cv = '0;  sv = -ONE; end
            TC_RY45_NEG: begin is_ry = 1'b1; cv = C45; sv = -C45; end
            TC_RY45_POS: begin is_ry = 1'b1; cv = C45; sv = C45;  end
            default:     begin is_tr = 1'b1; end
        endcase
        res = (r == c) ? ONE : '0;
        if (is_tr && c == 2'd3 && r == 2'd0) res = tx;
        if (is_tr && c == 2'd3 && r == 2'd1) res = ty;
        if (is_tr && c == 2'd3 && r == 2'd2) res = tz;
        if (is_dg && r == c && r != 2'd3) res = dv;
        if (is_rx && r == c && (r == 2'd1 || r == 2'd2)) res = cv;
        if (is_rx && r == 2'd1 && c == 2'd2) res = -sv;
        if (is_rx && r == 2'd2 && c == 2'd1) res = sv;
        if (is_ry && r == c && (r == 2'd0 || r == 2'd2)) res = cv;
        if (is_ry && r == 2'd0 && c == 2'd2) res = sv;
        if (is_ry && r == 2'd2 && c == 2'd0) res = -sv;
        return res;
    endfunction

    // Operand selection and multiply
    always_comb
    begin
        f_idx = (cmd.ptype == PT_FWD) ? {cmd.rk, cmd.rj} : {cmd.ri, cmd.rk};
        f_rd  = fwd_reg[f_idx];
        i_rd  = inv_reg[{cmd.ri, cmd.rk}];
        t_r   = (cmd.ptype == PT_FWD) ? cmd.ri : cmd.rk;
        t_c   = (cmd.ptype == PT_FWD) ? cmd.rk : cmd.rj;
        t_val = tf_elem(cmd.tcode, t_r, t_c, hw, hh);
        unique case (cmd.ptype)
            PT_FWD:  begin op_a = t_val; op_b = f_rd; end
            PT_INV:  begin op_a = i_rd;  op_b = t_val; end
            default: begin op_a = cmd.msel ? i_rd : f_rd; op_b = pt_reg[cmd.rk]; end
        endcase
        prod_next = op_a * op_b;
    end

    // Accumulate, round half up, saturate
    always_comb
    begin
        acc_next = first1_reg ? 66'(prod_reg) : acc_reg + 66'(prod_reg);
        rnd_sum  = acc_reg + RND;
        shifted  = rnd_sum >>> FRAC_BITS;
        if (shifted > SAT_HI)
            sat_val = 32'sh7FFFFFFF;
        else if (shifted < SAT_LO)
            sat_val = 32'sh80000000;
        else
            sat_val = shifted[31:0];
    end

    assign stat.busy     = v1_reg || v2_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    // Pipeline and output control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        first1_reg <= (cmd.rk == 2'd0);
        last1_reg  <= (cmd.rk == 2'd3);
        map1_reg   <= (cmd.ptype == PT_MAP);
        dst1_reg   <= {cmd.ri, cmd.rj};
        if (v1_reg)
            acc_reg <= acc_next;
        last2_reg <= last1_reg;
        map2_reg  <= map1_reg;
        dst2_reg  <= dst1_reg;
        if (v2_reg && last2_reg)
        begin
            if (map2_reg)
                res_reg[dst2_reg[3:2]] <= sat_val;
            else
                tmp_reg[dst2_reg] <= sat_val;
        end
        if (cmd.load_point)
        begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
            pt_reg[3] <= point_w;
        end
        if (cmd.publish)
        begin
            out_x_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
            out_z_reg <= res_reg[2];
            out_w_reg <= res_reg[3];
        end
    end

    // Matrix storage: initial view load and copy-back from the scratch matrix
    always_ff @(posedge clk)
    begin
        if (cmd.load_init)
        begin
            for (int n = 0; n < MSIZE; n++)
            begin
                if (n == 3)
                begin
                    fwd_reg[n] <= hw;
                    inv_reg[n] <= -hw;
                end
                else if (n == 5)
                begin
                    fwd_reg[n] <= -ONE;
                    inv_reg[n] <= -ONE;
                end
                else if (n == 7)
                begin
                    fwd_reg[n] <= hh;
                    inv_reg[n] <= hh;
                end
                else
                begin
                    fwd_reg[n] <= (n % (MATRIX_DIM + 1) == 0) ? ONE : '0;
                    inv_reg[n] <= (n % (MATRIX_DIM + 1) == 0) ? ONE : '0;
                end
            end
        end
        else if (cmd.copy)
        begin
            if (cmd.copy_inv)
                inv_reg[cmd.copy_idx] <= tmp_reg[cmd.copy_idx];
            else
                fwd_reg[cmd.copy_idx] <= tmp_reg[cmd.copy_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_w     = out_w_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vtc_checker.sv =====
// Port-level checks for the view transform composer.
// Bound to view_transform_composer_core; uses no package.
`default_nettype none

module vtc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [135:0] s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);

    // A stalled result holds its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A map request occupies the block
    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[3:1] == 3'd0)
        |=> !s_axis_tready)
        else $error("request taken during a map");

    // A matrix update blocks requests and raises no result straight after
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[3:1] != 3'd0)
        && (s_axis_tdata[3:0] != 4'd15) |=> !s_axis_tready ##1 !$rose(m_axis_tvalid))
        else $error("matrix update misbehaved");

endmodule

bind view_transform_composer_core vtc_checker u_vtc_checker (.*);

`default_nettype wire
